// ===== src/mi3_pkg.sv =====
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Depends on nothing; every other file of the block imports it.
package mi3_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ADJ_BITS  = 2 * WORD_BITS + 1;
  localparam int PART_BITS = 2 * WORD_BITS + 2;
  localparam int DET_BITS  = 3 * WORD_BITS + 3;
  localparam int NUM_A     = 2 * WORD_BITS + 2 * FRAC_BITS + 2;
  localparam int NUM_B     = 3 * WORD_BITS + 3;
  localparam int NUM_BITS  = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
  localparam int QUO_BITS  = WORD_BITS;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam int NUM_PROD = 18;

  // Element indexes (row-major) of the two factors of each cofactor product.
  // Adjugate entry j is product 2j minus product 2j+1.
  localparam logic [3:0] CROSS_A [NUM_PROD] = '{
    4'd4, 4'd7, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] CROSS_B [NUM_PROD] = '{
    4'd8, 4'd5, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t a00; word_t a01; word_t a02;
    word_t a10; word_t a11; word_t a12;
    word_t a20; word_t a21; word_t a22;
  } mat_in_t;

  typedef struct packed {
    word_t inv00; word_t inv01; word_t inv02;
    word_t inv10; word_t inv11; word_t inv12;
    word_t inv20; word_t inv21; word_t inv22;
    word_t det_value;
    logic  singular;
    logic  saturated;
  } mat_out_t;

  // Cofactor products plus the first row, passed from front to back.
  typedef struct packed {
    logic [NUM_PROD-1:0][PROD_BITS-1:0] p;
    logic [2:0][WORD_BITS-1:0]          row;
  } prod_t;

endpackage

// ===== src/mi3_front.sv =====
// Front stage: accepts a matrix and registers its eighteen cofactor products.
// Depends on mi3_pkg.
module mi3_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_ready,
  input  mi3_pkg::mat_in_t src_data,
  output logic            prod_valid,
  input  logic            prod_ready,
  output mi3_pkg::prod_t  prod_data
);
  import mi3_pkg::*;

  word_t e [9];
  logic  v;

  always_comb begin
    e[0] = src_data.a00; e[1] = src_data.a01; e[2] = src_data.a02;
    e[3] = src_data.a10; e[4] = src_data.a11; e[5] = src_data.a12;
    e[6] = src_data.a20; e[7] = src_data.a21; e[8] = src_data.a22;
  end

  assign src_ready  = !v || prod_ready;
  assign prod_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (src_ready) begin
      v <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      for (int k = 0; k < NUM_PROD; k++) begin
        prod_data.p[k] <= PROD_BITS'(e[CROSS_A[k]]) * PROD_BITS'(e[CROSS_B[k]]);
      end
      prod_data.row[0] <= e[0];
      prod_data.row[1] <= e[1];
      prod_data.row[2] <= e[2];
    end
  end

endmodule

// ===== src/mi3_fifo.sv =====
// Short queue between the front stage and the back pipeline.
// Depends on mi3_pkg.
module mi3_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mi3_pkg::prod_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mi3_pkg::prod_t pop_data
);
  import mi3_pkg::*;

  prod_t                    mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wp;
  logic [FIFO_PTR_BITS-1:0] rp;
  logic [FIFO_PTR_BITS:0]   count;
  logic                     push;
  logic                     pop;

  assign push_ready = count != (FIFO_PTR_BITS + 1)'(FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

endmodule

// ===== src/mi3_back.sv =====
// Back pipeline: adjugate, determinant, pipelined restoring divide, clip.
// Depends on mi3_pkg.
module mi3_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             prod_valid,
  output logic             prod_ready,
  input  mi3_pkg::prod_t   prod_data,
  output logic             res_valid,
  input  logic             res_ready,
  output mi3_pkg::mat_out_t res_data
);
  import mi3_pkg::*;

  typedef struct packed {
    logic [NUM_BITS-1:0] r;
    logic [QUO_BITS-1:0] q;
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]         lane;
    logic [NUM_BITS-1:0] dd;
    logic                sing;
    word_t               det_value;
    logic                det_sat;
  } div_t;

  // One quotient bit per lane: compare the remainder against the divisor
  // shifted up by sh, subtract if it fits.
  function automatic div_t div_step(div_t d, int sh);
    div_t o;
    logic ge;
    o = d;
    for (int j = 0; j < 9; j++) begin
      ge = (d.lane[j].r >> sh) >= d.dd;
      if (ge) o.lane[j].r = d.lane[j].r - (d.dd << sh);
      o.lane[j].q = {d.lane[j].q[QUO_BITS-2:0], ge};
    end
    return o;
  endfunction

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic adv;

  logic                       v1, v2, v3, v4;
  logic signed [ADJ_BITS-1:0] adj1 [9];
  logic signed [ADJ_BITS-1:0] adj2 [9];
  logic signed [ADJ_BITS-1:0] adj3 [9];
  logic signed [ADJ_BITS-1:0] adj4 [9];
  word_t                      row1 [3];
  logic signed [PART_BITS-1:0] lo2 [3];
  logic signed [PART_BITS-1:0] hi2 [3];
  logic signed [DET_BITS-1:0]  p3 [3];
  logic signed [DET_BITS-1:0]  det4;

  div_t                dv [QUO_BITS+1];
  logic [QUO_BITS:0]   dvv;
  div_t                prep;
  mat_out_t            res_next;

  // Advance the whole pipeline unless a finished result is held.
  assign adv        = !res_valid || res_ready;
  assign prod_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dvv       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= prod_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      dvv       <= {dvv[QUO_BITS-1:0], v4};
      res_valid <= dvv[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        adj1[j] <= ADJ_BITS'($signed(prod_data.p[2*j]))
                 - ADJ_BITS'($signed(prod_data.p[2*j+1]));
      end
      for (int k = 0; k < 3; k++) row1[k] <= prod_data.row[k];

      adj2 <= adj1;
      for (int k = 0; k < 3; k++) begin
        lo2[k] <= PART_BITS'(row1[k])
                * PART_BITS'($signed({1'b0, adj1[3*k][WORD_BITS-1:0]}));
        hi2[k] <= PART_BITS'(row1[k])
                * PART_BITS'($signed(adj1[3*k][ADJ_BITS-1:WORD_BITS]));
      end

      adj3 <= adj2;
      for (int k = 0; k < 3; k++) begin
        p3[k] <= (DET_BITS'(hi2[k]) <<< WORD_BITS) + DET_BITS'(lo2[k]);
      end

      adj4 <= adj3;
      det4 <= p3[0] + p3[1] + p3[2];

      dv[0] <= prep;
      for (int s = 0; s < QUO_BITS; s++) begin
        dv[s+1] <= div_step(dv[s], QUO_BITS - 1 - s);
      end

      res_data <= res_next;
    end
  end

  // Set up divide operands, determinant output and overflow pre-check.
  always_comb begin
    logic signed [DET_BITS-1:0] t;
    logic [DET_BITS-1:0]        dmag;
    logic [ADJ_BITS-1:0]        amag;
    logic [NUM_BITS-1:0]        num;
    logic [DET_BITS-WORD_BITS:0] top;
    t    = det4 >>> (2 * FRAC_BITS);
    dmag = det4[DET_BITS-1] ? DET_BITS'(-det4) : DET_BITS'(det4);
    top  = t[DET_BITS-1:WORD_BITS-1];
    prep.dd      = NUM_BITS'(dmag) << 1;
    prep.sing    = det4 == '0;
    prep.det_sat = !((&top) || !(|top));
    if (prep.det_sat) prep.det_value = t[DET_BITS-1] ? WORD_MIN : WORD_MAX;
    else              prep.det_value = t[WORD_BITS-1:0];
    for (int j = 0; j < 9; j++) begin
      amag = adj4[j][ADJ_BITS-1] ? ADJ_BITS'(-adj4[j]) : ADJ_BITS'(adj4[j]);
      num  = (NUM_BITS'(amag) << (2 * FRAC_BITS + 1)) + NUM_BITS'(dmag);
      prep.lane[j].r   = num;
      prep.lane[j].q   = '0;
      prep.lane[j].neg = adj4[j][ADJ_BITS-1] ^ det4[DET_BITS-1];
      prep.lane[j].ovf = (num >> QUO_BITS) >= prep.dd;
    end
  end

  // Apply sign, clip, and zero all nine inverse entries for a singular matrix.
  always_comb begin
    word_t               inv [9];
    logic                sat;
    logic [QUO_BITS-1:0] q;
    sat = dv[QUO_BITS].det_sat;
    for (int j = 0; j < 9; j++) begin
      q = dv[QUO_BITS].lane[j].q;
      if (dv[QUO_BITS].sing) begin
        inv[j] = '0;
      end else if (dv[QUO_BITS].lane[j].neg) begin
        if (dv[QUO_BITS].lane[j].ovf || (q[QUO_BITS-1] && (|q[QUO_BITS-2:0]))) begin
          inv[j] = WORD_MIN;
          sat    = 1'b1;
        end else begin
          inv[j] = WORD_BITS'(-q);
        end
      end else begin
        if (dv[QUO_BITS].lane[j].ovf || q[QUO_BITS-1]) begin
          inv[j] = WORD_MAX;
          sat    = 1'b1;
        end else begin
          inv[j] = WORD_BITS'(q);
        end
      end
    end
    res_next.inv00     = inv[0];
    res_next.inv01     = inv[1];
    res_next.inv02     = inv[2];
    res_next.inv10     = inv[3];
    res_next.inv11     = inv[4];
    res_next.inv12     = inv[5];
    res_next.inv20     = inv[6];
    res_next.inv21     = inv[7];
    res_next.inv22     = inv[8];
    res_next.det_value = dv[QUO_BITS].det_value;
    res_next.singular  = dv[QUO_BITS].sing;
    res_next.saturated = sat;
  end

endmodule

// ===== src/matrix3x3_inverse.sv =====
// Top level of the 3x3 Q16.16 matrix inverse (adjugate over determinant).
// Depends on mi3_pkg, mi3_front, mi3_fifo and mi3_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   src     | src_valid / src_ready | src_data: a00..a22 (mat_in_t)
//   res     | res_valid / res_ready | res_data: inv00..inv22, det_value,
//           |                       |           singular, saturated
//
// Takes one matrix per cycle and delivers one result per cycle while
// res_ready stays high. A request passes through the product register,
// the queue, four adjugate and determinant stages, divide setup, then the
// restoring divider with one quotient bit per stage for the nine Q16.16
// inverse lanes in parallel, and the output register.
// Reset (rst, synchronous) clears only valid bits and queue pointers.
// A held result freezes the back pipeline; the request queue then fills and
// src_ready drops only when the queue is full.
module matrix3x3_inverse (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  mi3_pkg::mat_in_t  src_data,
  output logic              res_valid,
  input  logic              res_ready,
  output mi3_pkg::mat_out_t res_data
);
  import mi3_pkg::*;

  // Front to queue.
  logic  f_valid;
  logic  f_ready;
  prod_t f_data;

  // Queue to back pipeline.
  logic  q_valid;
  logic  q_ready;
  prod_t q_data;

  // Accept a request and form its cofactor products.
  mi3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .prod_valid (f_valid),
    .prod_ready (f_ready),
    .prod_data  (f_data)
  );

  // Hold requests while the back pipeline stalls.
  mi3_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Adjugate, determinant, divide and clip.
  mi3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (q_valid),
    .prod_ready (q_ready),
    .prod_data  (q_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule
